// File: rtl/core/priority_packet_queue_with_drop_top_defines.svh
// Assertion macros for the priority packet queue.
// Used only by the top level.
`ifndef PRIORITY_PACKET_QUEUE_WITH_DROP_TOP_DEFINES_SVH
`define PRIORITY_PACKET_QUEUE_WITH_DROP_TOP_DEFINES_SVH
// Condition implies a property on the next edge.
`define PPQ_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);
// Condition implies a property on the same edge.
`define PPQ_ASSERT_NOW(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);
`endif

// File: rtl/core/ppq_pkg.sv
// Shared types and constants for the priority packet queue.
// No dependencies.
`timescale 1ns / 1ps
package ppq_pkg;
    localparam logic [19:0] CAP_RESET = 20'd65536;
    localparam logic [7:0]  OVH_RESET = 8'd0;
    localparam logic [31:0] BW_RESET  = 32'd1250000;
    localparam logic [19:0] USEC_PER_SEC = 20'd1000000;

    localparam logic [1:0] REG_CAPACITY  = 2'd0;
    localparam logic [1:0] REG_OVERHEAD  = 2'd1;
    localparam logic [1:0] REG_BANDWIDTH = 2'd2;

    localparam logic KIND_ENQ = 1'b0;
    localparam logic KIND_DEQ = 1'b1;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_DECIDE, S_POP_RD, S_POP_WB, S_ENQ_RD, S_ENQ_WB,
        S_DIV, S_DONE
    } t_state;

    // Divider control between top level and divider.
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } t_div_ctl;
endpackage

// File: rtl/core/ppq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module ppq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

// File: rtl/core/ppq_div.sv
// Restoring divider, one quotient bit per cycle, saturating to 32 bits.
// Depends on ppq_pkg.
`timescale 1ns / 1ps
module ppq_div (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [39:0]      i_num,
    input  logic [31:0]      i_den,
    output ppq_pkg::t_div_ctl o_ctl,
    output logic [31:0]      o_quot
);
    logic [39:0] r_num, n_num;
    logic [32:0] r_rem, n_rem;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [32:0] w_trial;
    logic [33:0] w_sub;

    // One shift-subtract step per cycle over the 40-bit numerator.
    always_comb begin
        n_num  = r_num;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        w_trial = {r_rem[31:0], r_num[39]};
        w_sub   = {1'b0, w_trial} - {2'b00, i_den};
        if (i_start) begin
            n_num  = i_num;
            n_rem  = '0;
            n_cnt  = 6'd40;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!w_sub[33]) begin
                n_rem = w_sub[32:0];
                n_num = {r_num[38:0], 1'b1};
            end else begin
                n_rem = w_trial;
                n_num = {r_num[38:0], 1'b0};
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_num <= n_num;
        r_rem <= n_rem;
    end

    // Quotient sits in r_num; saturate when zero divisor or upper bits set.
    assign o_quot = (i_den == 32'd0 || r_num[39:32] != 8'd0) ? 32'hFFFF_FFFF : r_num[31:0];
    assign o_ctl  = '{start: i_start, busy: r_busy, done: r_done};
endmodule

// File: rtl/core/priority_packet_queue_with_drop_top.sv
// Strict priority packet queue with push-out. Descriptors live in a linked
// list RAM (next link) and a length RAM shared by all classes; one operation
// is worked at a time. After reset a clearing pass chains every slot into the
// free list, during which no word is accepted. An enqueue passes a decide
// state, a free-list read and a write-back; each pushed-out packet adds a pop
// read and a pop write-back before the next decide. A dequeue pops the head of
// the highest-priority busy class, then waits on the bit-serial pacing divider.
// A bad length, an empty dequeue or a rejected enqueue (after its push-outs)
// goes from decide straight to done. A finished result sits in its own output
// register, so the next word is taken while it waits; the sequencer only holds
// in its last state while that register is still full.
`timescale 1ns / 1ps
`include "priority_packet_queue_with_drop_top_defines.svh"
module priority_packet_queue_with_drop_top #(
    parameter int CLASSES    = 2,
    parameter int SLOTS      = 128,
    parameter int MAX_PACKET = 2048
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_kind,
    input  logic        i_priority_class,
    input  logic [11:0] i_packet_length,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_accepted,
    output logic [6:0]  o_slot_index,
    output logic [6:0]  o_dropped_count,
    output logic        o_queue_empty,
    output logic [11:0] o_out_length,
    output logic        o_out_class,
    output logic [31:0] o_pacing_time_us
);
    localparam int SW = $clog2(SLOTS);
    localparam int CW = $clog2(CLASSES);
    localparam int FW = $clog2(SLOTS + 1);

    // Configuration registers.
    logic [19:0] r_cap;
    logic [7:0]  r_ovh;
    logic [31:0] r_bw;
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= ppq_pkg::CAP_RESET;
            r_ovh <= ppq_pkg::OVH_RESET;
            r_bw  <= ppq_pkg::BW_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                ppq_pkg::REG_CAPACITY:  r_cap <= i_cfg_data[19:0];
                ppq_pkg::REG_OVERHEAD:  r_ovh <= i_cfg_data[7:0];
                ppq_pkg::REG_BANDWIDTH: r_bw  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Queue state.
    ppq_pkg::t_state r_state, n_state;
    logic [SW-1:0] r_free_head, n_free_head;
    logic [FW-1:0] r_free_count, n_free_count;
    logic [SW-1:0] r_head [CLASSES];
    logic [SW-1:0] r_tail [CLASSES];
    logic [CLASSES-1:0] r_nonempty, n_nonempty;
    logic [20:0]   r_qbytes, n_qbytes;
    logic [SW-1:0] r_init, n_init;
    logic          r_kind, n_kind;
    logic [CW-1:0] r_cls, n_cls;
    logic [11:0]   r_len, n_len;
    logic [CW-1:0] r_pc, n_pc;         // class being popped
    logic [SW-1:0] r_ps, n_ps;         // slot being popped
    logic [6:0]    r_drop, n_drop;
    logic          r_ovalid, n_ovalid;
    logic          r_acc, n_acc;
    logic          r_qe, n_qe;
    logic [11:0]   r_olen, n_olen;
    logic          r_ocls, n_ocls;
    logic [6:0]    r_oslot, n_oslot;
    logic [31:0]   r_pace, n_pace;
    logic          w_hd_we, w_tl_we;
    logic [SW-1:0] w_hd_val, w_tl_val;
    logic [CW-1:0] w_hd_c, w_tl_c;

    // Result register, loaded when an operation finishes.
    logic          w_res_load;
    logic          r_res_acc;
    logic [6:0]    r_res_slot;
    logic [6:0]    r_res_drop;
    logic          r_res_qe;
    logic [11:0]   r_res_len;
    logic          r_res_cls;
    logic [31:0]   r_res_pace;

    // RAM ports.
    logic          w_lk_we, w_ln_we;
    logic [SW-1:0] w_lk_wa, w_lk_wd, w_lk_ra, w_lk_rd;
    logic [SW-1:0] w_ln_wa, w_ln_ra;
    logic [11:0]   w_ln_wd, w_ln_rd;

    ppq_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_link (
        .i_clk(i_clk), .i_we(w_lk_we), .i_waddr(w_lk_wa), .i_wdata(w_lk_wd),
        .i_raddr(w_lk_ra), .o_rdata(w_lk_rd)
    );
    ppq_ram #(.WIDTH(12), .DEPTH(SLOTS)) u_len (
        .i_clk(i_clk), .i_we(w_ln_we), .i_waddr(w_ln_wa), .i_wdata(w_ln_wd),
        .i_raddr(w_ln_ra), .o_rdata(w_ln_rd)
    );

    // Pacing divider.
    logic              w_div_start;
    ppq_pkg::t_div_ctl w_div_ctl;
    logic [31:0]       w_quot;
    logic [12:0]       w_total;
    logic [39:0]       w_num;
    assign w_total = {1'b0, w_ln_rd} + {5'd0, r_ovh};
    assign w_num   = {27'd0, w_total} * {20'd0, ppq_pkg::USEC_PER_SEC};
    ppq_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_div_start), .i_num(w_num),
        .i_den(r_bw), .o_ctl(w_div_ctl), .o_quot(w_quot)
    );

    // Victim search: highest non-empty class above r_cls.
    logic          w_vic_found;
    logic [CW-1:0] w_vic;
    always_comb begin
        w_vic_found = 1'b0;
        w_vic = '0;
        for (int p = 0; p < CLASSES; p++) begin
            if (CW'(p) > r_cls && r_nonempty[p]) begin
                w_vic_found = 1'b1;
                w_vic = CW'(p);
            end
        end
    end
    // Dequeue search: lowest non-empty class.
    logic          w_deq_found;
    logic [CW-1:0] w_deq;
    always_comb begin
        w_deq_found = 1'b0;
        w_deq = '0;
        for (int p = CLASSES - 1; p >= 0; p--) begin
            if (r_nonempty[p]) begin
                w_deq_found = 1'b1;
                w_deq = CW'(p);
            end
        end
    end

    logic w_full, w_over;
    assign w_full = (r_free_count == '0);
    assign w_over = ({9'd0, r_len} + r_qbytes) > {1'b0, r_cap};
    logic [CW-1:0] w_in_cls;
    assign w_in_cls = (CLASSES > 2 && CW'(i_priority_class) >= CW'(CLASSES - 1)) ?
                      CW'(CLASSES - 1) : CW'(i_priority_class);

    assign o_ready = (r_state == ppq_pkg::S_IDLE);

    // Sequencer: next state, RAM accesses and results.
    always_comb begin
        n_state = r_state;
        n_free_head = r_free_head;
        n_free_count = r_free_count;
        n_nonempty = r_nonempty;
        n_qbytes = r_qbytes;
        n_init = r_init;
        n_kind = r_kind; n_cls = r_cls; n_len = r_len;
        n_pc = r_pc; n_ps = r_ps; n_drop = r_drop;
        n_ovalid = r_ovalid; n_acc = r_acc; n_qe = r_qe;
        n_olen = r_olen; n_ocls = r_ocls; n_oslot = r_oslot; n_pace = r_pace;
        w_hd_we = 1'b0; w_hd_val = '0; w_hd_c = '0;
        w_tl_we = 1'b0; w_tl_val = '0; w_tl_c = '0;
        w_lk_we = 1'b0; w_lk_wa = '0; w_lk_wd = '0; w_lk_ra = '0;
        w_ln_we = 1'b0; w_ln_wa = '0; w_ln_wd = '0; w_ln_ra = r_ps;
        w_div_start = 1'b0;
        w_res_load = 1'b0;
        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end
        unique case (r_state)
            ppq_pkg::S_INIT: begin
                // Chain every slot into the free list.
                w_lk_we = 1'b1;
                w_lk_wa = r_init;
                w_lk_wd = r_init + SW'(1);
                n_init = r_init + SW'(1);
                if (r_init == SW'(SLOTS - 1)) begin
                    n_state = ppq_pkg::S_IDLE;
                end
            end
            ppq_pkg::S_IDLE: begin
                if (i_valid && o_ready) begin
                    n_kind = i_kind;
                    n_cls = w_in_cls;
                    n_len = i_packet_length;
                    n_drop = '0;
                    n_state = ppq_pkg::S_DECIDE;
                end
            end
            ppq_pkg::S_DECIDE: begin
                n_acc = 1'b0; n_qe = 1'b0; n_olen = '0; n_ocls = 1'b0;
                n_oslot = '0; n_pace = '0;
                if (r_kind == ppq_pkg::KIND_DEQ) begin
                    if (w_deq_found) begin
                        n_pc = w_deq;
                        n_ps = r_head[w_deq];
                        n_state = ppq_pkg::S_POP_RD;
                    end else begin
                        n_qe = 1'b1;
                        n_state = ppq_pkg::S_DONE;
                    end
                end else if (r_len == 12'd0 || {4'd0, r_len} > 16'(MAX_PACKET)) begin
                    n_state = ppq_pkg::S_DONE;
                end else if (w_full || w_over) begin
                    if (w_vic_found) begin
                        n_pc = w_vic;
                        n_ps = r_head[w_vic];
                        n_state = ppq_pkg::S_POP_RD;
                    end else begin
                        n_state = ppq_pkg::S_DONE;
                    end
                end else begin
                    n_state = ppq_pkg::S_ENQ_RD;
                end
            end
            ppq_pkg::S_POP_RD: begin
                // Fetch the popped slot's link and length.
                w_lk_ra = r_ps;
                n_state = ppq_pkg::S_POP_WB;
            end
            ppq_pkg::S_POP_WB: begin
                if (r_ps == r_tail[r_pc]) begin
                    n_nonempty[r_pc] = 1'b0;
                end else begin
                    w_hd_we = 1'b1; w_hd_c = r_pc; w_hd_val = w_lk_rd;
                end
                n_qbytes = r_qbytes - {9'd0, w_ln_rd};
                w_lk_we = 1'b1; w_lk_wa = r_ps; w_lk_wd = r_free_head;
                n_free_head = r_ps;
                n_free_count = r_free_count + FW'(1);
                if (r_kind == ppq_pkg::KIND_DEQ) begin
                    n_acc = 1'b1;
                    n_oslot = 7'(r_ps);
                    n_olen = w_ln_rd;
                    n_ocls = r_pc[0];
                    w_div_start = 1'b1;
                    n_state = ppq_pkg::S_DIV;
                end else begin
                    if (r_drop != 7'd127) begin
                        n_drop = r_drop + 7'd1;
                    end
                    n_state = ppq_pkg::S_DECIDE;
                end
            end
            ppq_pkg::S_DIV: begin
                if (w_div_ctl.done) begin
                    n_pace = w_quot;
                    n_state = ppq_pkg::S_DONE;
                end
            end
            ppq_pkg::S_ENQ_RD: begin
                w_lk_ra = r_free_head;
                n_state = ppq_pkg::S_ENQ_WB;
            end
            ppq_pkg::S_ENQ_WB: begin
                n_free_head = w_lk_rd;
                n_free_count = r_free_count - FW'(1);
                w_ln_we = 1'b1; w_ln_wa = r_free_head; w_ln_wd = r_len;
                if (r_nonempty[r_cls]) begin
                    w_lk_we = 1'b1; w_lk_wa = r_tail[r_cls]; w_lk_wd = r_free_head;
                end else begin
                    w_hd_we = 1'b1; w_hd_c = r_cls; w_hd_val = r_free_head;
                end
                w_tl_we = 1'b1; w_tl_c = r_cls; w_tl_val = r_free_head;
                n_nonempty[r_cls] = 1'b1;
                n_qbytes = r_qbytes + {9'd0, r_len};
                n_acc = 1'b1;
                n_oslot = 7'(r_free_head);
                n_state = ppq_pkg::S_DONE;
            end
            ppq_pkg::S_DONE: begin
                // Hand the word over once the result register is free.
                if (!r_ovalid || i_ready) begin
                    w_res_load = 1'b1;
                    n_ovalid = 1'b1;
                    n_state = ppq_pkg::S_IDLE;
                end
            end
            default: n_state = ppq_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ppq_pkg::S_INIT;
            r_init <= '0;
            r_free_head <= '0;
            r_free_count <= FW'(SLOTS);
            r_nonempty <= '0;
            r_qbytes <= '0;
            r_ovalid <= 1'b0;
            for (int c = 0; c < CLASSES; c++) begin
                r_head[c] <= '0;
                r_tail[c] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_init <= n_init;
            r_free_head <= n_free_head;
            r_free_count <= n_free_count;
            r_nonempty <= n_nonempty;
            r_qbytes <= n_qbytes;
            r_ovalid <= n_ovalid;
            if (w_hd_we) r_head[w_hd_c] <= w_hd_val;
            if (w_tl_we) r_tail[w_tl_c] <= w_tl_val;
        end
        r_kind <= n_kind; r_cls <= n_cls; r_len <= n_len;
        r_pc <= n_pc; r_ps <= n_ps; r_drop <= n_drop;
        r_acc <= n_acc; r_qe <= n_qe; r_olen <= n_olen; r_ocls <= n_ocls;
        r_oslot <= n_oslot; r_pace <= n_pace;
        if (w_res_load) begin
            r_res_acc  <= r_acc;
            r_res_slot <= r_oslot;
            r_res_drop <= (r_kind == ppq_pkg::KIND_DEQ) ? 7'd0 : r_drop;
            r_res_qe   <= r_qe;
            r_res_len  <= r_olen;
            r_res_cls  <= r_ocls;
            r_res_pace <= r_pace;
        end
    end

    assign o_valid = r_ovalid;
    assign o_accepted = r_res_acc;
    assign o_slot_index = r_res_slot;
    assign o_dropped_count = r_res_drop;
    assign o_queue_empty = r_res_qe;
    assign o_out_length = r_res_len;
    assign o_out_class = r_res_cls;
    assign o_pacing_time_us = r_res_pace;

    // Checks on the sequencer.
    `PPQ_ASSERT_NOW(a_free_bound, i_clk, i_rst_n, 1'b1, r_free_count <= FW'(SLOTS), "free count above slot total")
    `PPQ_ASSERT_NOW(a_div_only_deq, i_clk, i_rst_n, w_div_ctl.start, r_kind == ppq_pkg::KIND_DEQ, "divider started on enqueue")
    `PPQ_ASSERT_NEXT(a_no_take_busy, i_clk, i_rst_n, i_valid && o_ready, r_state == ppq_pkg::S_DECIDE, "word taken but no decide")
endmodule

// File: verif/ppq_checker.sv
// Checker for the priority packet queue: watches the config, request and
// result channels, predicts each result and compares it. Depends on ppq_pkg.
`timescale 1ns / 1ps
module ppq_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    input  logic        i_ready,
    input  logic        i_kind,
    input  logic        i_priority_class,
    input  logic [11:0] i_packet_length,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic        i_accepted,
    input  logic [6:0]  i_slot_index,
    input  logic [6:0]  i_dropped_count,
    input  logic        i_queue_empty,
    input  logic [11:0] i_out_length,
    input  logic        i_out_class,
    input  logic [31:0] i_pacing_time_us,
    output int          o_fail_count,
    output int          o_pending
);
    localparam int NSLOT = 128;
    localparam int NCLS  = 2;
    localparam int MAXLEN = 2048;

    typedef struct packed {
        logic        accepted;
        logic [6:0]  slot_index;
        logic [6:0]  dropped_count;
        logic        queue_empty;
        logic [11:0] out_length;
        logic        out_class;
        logic [31:0] pacing_time_us;
    } t_result;

    // Shadow of the queue state and registers
    logic [19:0] cap_q;
    logic [7:0]  ovh_q;
    logic [31:0] bw_q;
    logic [6:0]  link_q [NSLOT];
    logic [11:0] len_q [NSLOT];
    logic [6:0]  free_head_q;
    int          free_cnt_q;
    logic [6:0]  head_q [NCLS];
    logic [6:0]  tail_q [NCLS];
    logic        busy_q [NCLS];
    int unsigned bytes_q;

    t_result result_fifo[$];
    int      fails;

    assign o_fail_count = fails;

    function automatic logic [6:0] unlink_head(int c);
        logic [6:0] s;
        s = head_q[c];
        if (s == tail_q[c]) busy_q[c] = 1'b0;
        else head_q[c] = link_q[s];
        bytes_q -= len_q[s];
        link_q[s] = free_head_q;
        free_head_q = s;
        free_cnt_q++;
        return s;
    endfunction

    // Evict head of the lowest-priority busy class below cls
    function automatic bit evict_below(int cls);
        for (int p = NCLS - 1; p > cls; p--) begin
            if (busy_q[p]) begin
                void'(unlink_head(p));
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic t_result queue_op(logic kind, logic cls_in, logic [11:0] len);
        t_result r;
        int cls, drops;
        logic [6:0] s;
        logic [63:0] total, t;
        r = '0;
        cls = cls_in;
        drops = 0;
        if (kind == ppq_pkg::KIND_ENQ) begin
            if (len == 0 || len > MAXLEN) return r;
            if (free_cnt_q == 0) begin
                if (!evict_below(cls)) return r;
                drops++;
            end
            while (64'(len) + bytes_q > cap_q) begin
                if (!evict_below(cls)) begin
                    r.dropped_count = drops > 127 ? 7'd127 : 7'(drops);
                    return r;
                end
                drops++;
            end
            s = free_head_q;
            free_head_q = link_q[s];
            free_cnt_q--;
            len_q[s] = len;
            if (busy_q[cls]) link_q[tail_q[cls]] = s;
            else head_q[cls] = s;
            tail_q[cls] = s;
            busy_q[cls] = 1'b1;
            bytes_q += len;
            r.accepted = 1'b1;
            r.slot_index = s;
            r.dropped_count = drops > 127 ? 7'd127 : 7'(drops);
            return r;
        end
        for (int c = 0; c < NCLS; c++) begin
            if (busy_q[c]) begin
                s = unlink_head(c);
                total = 64'(len_q[s]) + ovh_q;
                if (bw_q == 0) t = 64'hFFFF_FFFF;
                else begin
                    t = (total * 64'd1000000) / bw_q;
                    if (t > 64'hFFFF_FFFF) t = 64'hFFFF_FFFF;
                end
                r.accepted = 1'b1;
                r.slot_index = s;
                r.out_length = len_q[s];
                r.out_class = 1'(c);
                r.pacing_time_us = t[31:0];
                return r;
            end
        end
        r.queue_empty = 1'b1;
        return r;
    endfunction

    // Track handshakes and compare results
    always @(posedge i_clk) begin
        t_result got, want;
        if (!i_rst_n) begin
            cap_q = ppq_pkg::CAP_RESET;
            ovh_q = ppq_pkg::OVH_RESET;
            bw_q  = ppq_pkg::BW_RESET;
            for (int i = 0; i < NSLOT; i++) begin
                link_q[i] = 7'(i + 1);
                len_q[i] = '0;
            end
            free_head_q = '0;
            free_cnt_q = NSLOT;
            for (int i = 0; i < NCLS; i++) begin
                head_q[i] = '0;
                tail_q[i] = '0;
                busy_q[i] = 1'b0;
            end
            bytes_q = 0;
            result_fifo.delete();
            fails = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    ppq_pkg::REG_CAPACITY:  cap_q = i_cfg_data[19:0];
                    ppq_pkg::REG_OVERHEAD:  ovh_q = i_cfg_data[7:0];
                    ppq_pkg::REG_BANDWIDTH: bw_q  = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_res_valid && i_res_ready) begin
                got = '{i_accepted, i_slot_index, i_dropped_count, i_queue_empty,
                        i_out_length, i_out_class, i_pacing_time_us};
                if (result_fifo.size() == 0) begin
                    fails++;
                    if (fails <= 10) $display("unexpected result word %p", got);
                end else begin
                    want = result_fifo.pop_front();
                    if (got !== want) begin
                        fails++;
                        if (fails <= 10)
                            $display("mismatch: expected %p got %p", want, got);
                    end
                end
            end
            if (i_valid && i_ready)
                result_fifo.push_back(queue_op(i_kind, i_priority_class, i_packet_length));
        end
        o_pending = result_fifo.size();
    end
endmodule

// File: verif/tb_priority_packet_queue_with_drop_top.sv
// Testbench top for the priority packet queue: drives config and request
// words, stalls the result side and gives the verdict. Needs ppq_checker.
`timescale 1ns / 1ps
module tb_priority_packet_queue_with_drop_top;
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_kind = 1'b0;
    logic        i_priority_class = 1'b0;
    logic [11:0] i_packet_length = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic        o_accepted;
    logic [6:0]  o_slot_index;
    logic [6:0]  o_dropped_count;
    logic        o_queue_empty;
    logic [11:0] o_out_length;
    logic        o_out_class;
    logic [31:0] o_pacing_time_us;
    int          fail_count;
    int          pending;
    bit          sending_done = 1'b0;
    int          stall_left = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    priority_packet_queue_with_drop_top DUT (.*);

    ppq_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index,
        .i_cfg_data, .i_valid, .i_ready(o_ready), .i_kind, .i_priority_class,
        .i_packet_length, .i_res_valid(o_valid), .i_res_ready(i_ready),
        .i_accepted(o_accepted), .i_slot_index(o_slot_index),
        .i_dropped_count(o_dropped_count), .i_queue_empty(o_queue_empty),
        .i_out_length(o_out_length), .i_out_class(o_out_class),
        .i_pacing_time_us(o_pacing_time_us), .o_fail_count(fail_count),
        .o_pending(pending)
    );

    // Mostly short gaps, occasionally long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Valid drops after each word is taken, before the next word is driven
    task automatic send_word(logic kind, logic cls, logic [11:0] len);
        i_kind <= kind;
        i_priority_class <= cls;
        i_packet_length <= len;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
        i_valid <= 1'b0;
        repeat (1 + gap_len()) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        i_cfg_index <= idx;
        i_cfg_data <= data;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic drain();
        while (pending != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    // Random length: mostly mid sizes, some at the extremes
    function automatic logic [11:0] pick_len();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 12'($urandom_range(0, 4095));
        if (r == 1) return 12'd2048;
        if (r == 2) return 12'd1;
        return 12'($urandom_range(1, 2048));
    endfunction

    // Result side stalls, mostly short, a few long
    always @(negedge i_clk) begin
        if (sending_done) begin
            i_ready <= 1'b1;
        end else if (stall_left > 0) begin
            i_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            i_ready <= 1'b1;
            if ($urandom_range(0, 2) == 0) stall_left <= gap_len();
        end
    end

    initial begin
        #5000000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty dequeue, bad lengths, extremes, push-out, saturation
        send_word(ppq_pkg::KIND_DEQ, 1'b0, 12'd0);
        send_word(ppq_pkg::KIND_ENQ, 1'b0, 12'd0);
        send_word(ppq_pkg::KIND_ENQ, 1'b1, 12'd4095);
        send_word(ppq_pkg::KIND_ENQ, 1'b1, 12'd2049);
        send_word(ppq_pkg::KIND_ENQ, 1'b1, 12'd1);
        send_word(ppq_pkg::KIND_ENQ, 1'b0, 12'd2048);
        send_word(ppq_pkg::KIND_DEQ, 1'b1, 12'd0);
        send_word(ppq_pkg::KIND_DEQ, 1'b0, 12'd0);
        send_word(ppq_pkg::KIND_DEQ, 1'b0, 12'd0);
        drain();
        write_reg(ppq_pkg::REG_CAPACITY, 32'd3000);
        write_reg(ppq_pkg::REG_OVERHEAD, 32'd255);
        write_reg(ppq_pkg::REG_BANDWIDTH, 32'd1);
        send_word(ppq_pkg::KIND_ENQ, 1'b1, 12'd1500);
        send_word(ppq_pkg::KIND_ENQ, 1'b1, 12'd1400);
        send_word(ppq_pkg::KIND_ENQ, 1'b0, 12'd2048);
        send_word(ppq_pkg::KIND_ENQ, 1'b1, 12'd2048);
        send_word(ppq_pkg::KIND_ENQ, 1'b0, 12'd2048);
        send_word(ppq_pkg::KIND_DEQ, 1'b0, 12'd0);
        send_word(ppq_pkg::KIND_DEQ, 1'b0, 12'd0);
        drain();
        write_reg(ppq_pkg::REG_BANDWIDTH, 32'd0);
        write_reg(ppq_pkg::REG_CAPACITY, 32'd0);
        send_word(ppq_pkg::KIND_ENQ, 1'b0, 12'd5);
        drain();
        write_reg(ppq_pkg::REG_CAPACITY, 32'hFFFFF);
        write_reg(ppq_pkg::REG_OVERHEAD, 32'd0);
        write_reg(ppq_pkg::REG_BANDWIDTH, 32'hFFFFFFFF);
        // Fill every slot with class 1, then class 0 pushes out several
        for (int i = 0; i < 130; i++) send_word(ppq_pkg::KIND_ENQ, 1'b1, 12'd8);
        for (int i = 0; i < 3; i++) send_word(ppq_pkg::KIND_ENQ, 1'b0, 12'd8);
        send_word(ppq_pkg::KIND_DEQ, 1'b0, 12'd0);
        drain();

        // Random phases with different settings
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin write_reg(ppq_pkg::REG_CAPACITY, 32'd65536);
                   write_reg(ppq_pkg::REG_BANDWIDTH, 32'd1250000); end
                1: begin write_reg(ppq_pkg::REG_CAPACITY, 32'd1);
                   write_reg(ppq_pkg::REG_OVERHEAD, 32'd255); end
                2: begin write_reg(ppq_pkg::REG_CAPACITY, 32'd20000);
                   write_reg(ppq_pkg::REG_BANDWIDTH, 32'd7); end
                3: begin write_reg(ppq_pkg::REG_CAPACITY, 32'hFFFFF);
                   write_reg(ppq_pkg::REG_OVERHEAD, 32'd0);
                   write_reg(ppq_pkg::REG_BANDWIDTH, $urandom); end
                4: begin write_reg(ppq_pkg::REG_CAPACITY,
                                   32'($urandom_range(1, 1048575)));
                   write_reg(ppq_pkg::REG_OVERHEAD, 32'($urandom_range(0, 255)));
                   write_reg(ppq_pkg::REG_BANDWIDTH, $urandom); end
                default: begin write_reg(ppq_pkg::REG_CAPACITY, 32'd8000);
                   write_reg(ppq_pkg::REG_BANDWIDTH, 32'd125000000); end
            endcase
            for (int i = 0; i < 150; i++) begin
                // Enqueue-heavy bursts keep the pool busy; dequeues drain it
                if ($urandom_range(0, 99) < ((i / 40) % 2 ? 35 : 65))
                    send_word(ppq_pkg::KIND_ENQ, 1'($urandom), pick_len());
                else
                    send_word(ppq_pkg::KIND_DEQ, 1'($urandom), 12'($urandom));
            end
            drain();
        end

        sending_done = 1'b1;
        while (pending != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

// File: files.f
+incdir+rtl/core
rtl/core/ppq_pkg.sv
rtl/core/ppq_ram.sv
rtl/core/ppq_div.sv
rtl/core/priority_packet_queue_with_drop_top.sv
verif/ppq_checker.sv
verif/tb_priority_packet_queue_with_drop_top.sv
